### src/zpr_pkg.sv
// ----------------------------------------------------------------------------
// zpr_pkg
// Shared types and constants for the zigzag position / ring level core.
// ----------------------------------------------------------------------------
package zpr_pkg;

	localparam int MAX_SIZE_DEF = 64;

	// Fixed field widths of the command and result ports
	localparam int W_SIZE  = 7;
	localparam int W_INDEX = 13;
	localparam int W_COORD = 6;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_CLAMP,
		ST_WALK,
		ST_DONE
	} state_t;

	// Controller to datapath
	typedef struct packed {
		logic load;
		logic mul;
		logic clamp;
		logic step;
		logic finish;
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic steps_zero;
	} status_t;

endpackage

### src/zpr_ctrl.sv
// ----------------------------------------------------------------------------
// zpr_ctrl
// Sequencer: load, square the size, clamp the index, walk, report.
// ----------------------------------------------------------------------------
module zpr_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  zpr_pkg::status_t status,
	output zpr_pkg::cmd_t    cmd,
	output logic             busy,
	output logic             done
);
	import zpr_pkg::*;

	state_t state_q;
	state_t state_nxt;
	logic   accept;

	// a result cycle does not block the next transfer
	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE, ST_DONE: begin
				if (accept) state_nxt = ST_MUL;
				else        state_nxt = ST_IDLE;
			end
			ST_MUL:   state_nxt = ST_CLAMP;
			ST_CLAMP: state_nxt = ST_WALK;
			ST_WALK: begin
				if (status.steps_zero) state_nxt = ST_DONE;
			end
			default:  state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd    = '0;
		busy   = 1'b1;
		done   = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				busy     = 1'b0;
				cmd.load = accept;
			end
			ST_DONE: begin
				busy     = 1'b0;
				done     = 1'b1;
				cmd.load = accept;
			end
			ST_MUL:   cmd.mul   = 1'b1;
			ST_CLAMP: cmd.clamp = 1'b1;
			ST_WALK: begin
				cmd.step   = !status.steps_zero;
				cmd.finish = status.steps_zero;
			end
			default: busy = 1'b0;
		endcase
	end

endmodule

### src/zpr_datapath.sv
// ----------------------------------------------------------------------------
// zpr_datapath
// Size/index conditioning, step counter, zigzag walker and ring level.
// ----------------------------------------------------------------------------
module zpr_datapath #(
	parameter int MAX_SIZE = zpr_pkg::MAX_SIZE_DEF
) (
	input  logic                         clk,
	input  zpr_pkg::cmd_t                cmd,
	input  logic [zpr_pkg::W_SIZE-1:0]   grid_size,
	input  logic [zpr_pkg::W_INDEX-1:0]  scan_index,
	output zpr_pkg::status_t             status,
	output logic [zpr_pkg::W_COORD-1:0]  row,
	output logic [zpr_pkg::W_COORD-1:0]  col,
	output logic [zpr_pkg::W_COORD-1:0]  ring_level,
	output logic                         index_clamped
);
	import zpr_pkg::*;

	localparam int CLOG = $clog2(MAX_SIZE);
	localparam int CW   = (CLOG > W_COORD) ? CLOG : W_COORD;    // coordinate width
	localparam int NW   = CW + 1;                                // size, holds MAX_SIZE
	localparam int TW   = 2 * CW + 1;                            // n*n
	localparam int SW   = 2 * CW;                                // step count
	localparam int MW   = (TW > W_INDEX) ? TW : W_INDEX;         // compare width

	logic [NW-1:0]     n_q;
	logic [W_INDEX-1:0] idx_q;
	logic [TW-1:0]     total_q;
	logic [SW-1:0]     steps_q;
	logic              clamp_q;
	logic [CW-1:0]     r_q, c_q;
	logic              down_q;
	logic [CW-1:0]     row_q, col_q, ring_q;
	logic              flag_q;

	logic [NW-1:0]     n_in;
	logic [2*NW-1:0]   prod;
	logic [MW-1:0]     idx_ext, tot_ext, sel, sel_m1;
	logic              over;
	logic [CW-1:0]     nm1;
	logic [CW-1:0]     r_nxt, c_nxt;
	logic              down_nxt;
	logic [CW-1:0]     min_lo, min_hi, ring_nxt;

	// zero size reads as one, oversize saturates
	always_comb begin
		n_in = NW'(grid_size);
		if (n_in == '0) n_in = NW'(1);
		if (n_in > NW'(MAX_SIZE)) n_in = NW'(MAX_SIZE);
	end

	assign prod    = (2*NW)'(n_q) * (2*NW)'(n_q);
	assign nm1     = CW'(n_q - NW'(1));
	assign idx_ext = MW'(idx_q);
	assign tot_ext = MW'(total_q);
	assign over    = idx_ext > tot_ext;
	assign sel     = over ? tot_ext : idx_ext;
	assign sel_m1  = sel - MW'(1);

	// one zigzag move; corner turns fold into the edge cases
	always_comb begin
		r_nxt    = r_q;
		c_nxt    = c_q;
		down_nxt = down_q;
		if (!down_q) begin
			priority if (c_q == nm1) begin
				r_nxt    = r_q + CW'(1);
				down_nxt = 1'b1;
			end else if (r_q == '0) begin
				c_nxt    = c_q + CW'(1);
				down_nxt = 1'b1;
			end else begin
				r_nxt = r_q - CW'(1);
				c_nxt = c_q + CW'(1);
			end
		end else begin
			priority if (r_q == nm1) begin
				c_nxt    = c_q + CW'(1);
				down_nxt = 1'b0;
			end else if (c_q == '0) begin
				r_nxt    = r_q + CW'(1);
				down_nxt = 1'b0;
			end else begin
				r_nxt = r_q + CW'(1);
				c_nxt = c_q - CW'(1);
			end
		end
	end

	always_comb begin
		min_lo   = (r_q < c_q) ? r_q : c_q;
		min_hi   = ((nm1 - r_q) < (nm1 - c_q)) ? (nm1 - r_q) : (nm1 - c_q);
		ring_nxt = ((min_lo < min_hi) ? min_lo : min_hi) + CW'(1);
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			n_q   <= n_in;
			idx_q <= (scan_index == '0) ? W_INDEX'(1) : scan_index;
		end
		if (cmd.mul) begin
			total_q <= prod[TW-1:0];
		end
		if (cmd.clamp) begin
			steps_q <= sel_m1[SW-1:0];
			clamp_q <= over;
			r_q     <= '0;
			c_q     <= '0;
			down_q  <= 1'b0;
		end
		if (cmd.step) begin
			steps_q <= steps_q - SW'(1);
			r_q     <= r_nxt;
			c_q     <= c_nxt;
			down_q  <= down_nxt;
		end
		if (cmd.finish) begin
			row_q  <= r_q;
			col_q  <= c_q;
			ring_q <= ring_nxt;
			flag_q <= clamp_q;
		end
	end

	assign status.steps_zero = (steps_q == '0);
	assign row           = row_q[W_COORD-1:0];
	assign col           = col_q[W_COORD-1:0];
	assign ring_level    = ring_q[W_COORD-1:0];
	assign index_clamped = flag_q;

endmodule

### src/zigzag_position_ring_level_core.sv
// Sequence: load, square n, clamp, walk, then done; k = effective index
// (index 0 as 1, clamped to n*n); the walker makes one zigzag move per cycle.
// A new query is not taken while the walk runs; the next start is taken in the cycle
// done is high. Results are not held off by the receiver.
// Reset: arst_n clears the sequencer to idle at once; no result is pending.
// ----------------------------------------------------------------------------
// zigzag_position_ring_level_core
// Zigzag scan position of a one-based index in an n x n grid, with ring level.
// ----------------------------------------------------------------------------
module zigzag_position_ring_level_core #(
	parameter int MAX_SIZE = zpr_pkg::MAX_SIZE_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic [zpr_pkg::W_SIZE-1:0]   grid_size,
	input  logic [zpr_pkg::W_INDEX-1:0]  scan_index,
	output logic                         done,
	output logic [zpr_pkg::W_COORD-1:0]  row,
	output logic [zpr_pkg::W_COORD-1:0]  col,
	output logic [zpr_pkg::W_COORD-1:0]  ring_level,
	output logic                         index_clamped
);
	import zpr_pkg::*;

	cmd_t    cmd;
	status_t status;

	zpr_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.status (status),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	zpr_datapath #(
		.MAX_SIZE (MAX_SIZE)
	) u_dp (
		.clk           (clk),
		.cmd           (cmd),
		.grid_size     (grid_size),
		.scan_index    (scan_index),
		.status        (status),
		.row           (row),
		.col           (col),
		.ring_level    (ring_level),
		.index_clamped (index_clamped)
	);

endmodule

### src/zpr_checker.sv
// ----------------------------------------------------------------------------
// zpr_checker
// Port-level checks on the zigzag core, bound to the top level.
// ----------------------------------------------------------------------------
module zpr_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         start,
	input logic                         busy,
	input logic                         done,
	input logic [zpr_pkg::W_COORD-1:0]  row,
	input logic [zpr_pkg::W_COORD-1:0]  col,
	input logic                         index_clamped
);

	// a transfer always leads to a busy period
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("busy not raised after start transfer");

	// each walk ends in exactly one result cycle
	a_fell_done: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("busy dropped without a result");

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("done held longer than one cycle");

	// a clamped index lands on the last cell, on the main diagonal
	a_clamp_diag: assert property (@(posedge clk) disable iff (!arst_n)
		done && index_clamped |-> row == col)
		else $error("clamped result off the last cell");

endmodule

bind zigzag_position_ring_level_core zpr_checker u_zpr_checker (.*);
